// ===== design/bqd_pkg.sv =====
package bqd_pkg;

  // coefficient and delay formats are fixed by the register map
  localparam int COEF_W    = 19;
  localparam int DELAY_W   = 40;
  localparam int NUM_COEFS = 5;
  localparam int IDX_W     = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  localparam logic signed [COEF_W-1:0] B0_RESET = 19'sd65536;

  // kind field codes
  localparam logic KIND_FILTER = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_B0   = 8'b0000_0010,
    ST_Y    = 8'b0000_0100,
    ST_A1   = 8'b0000_1000,
    ST_B2   = 8'b0001_0000,
    ST_A2   = 8'b0010_0000,
    ST_N2   = 8'b0100_0000,
    ST_CLR  = 8'b1000_0000
  } state_t;

endpackage

// ===== design/biquad_iir_filter_df2t_top.sv =====
// Channel  Direction  Handshake           Payload
// -------  ---------  ------------------  ---------------------------------
// in       input      in_valid/in_stall   in_kind, in_sample_in
// out      output     out_valid/out_stall out_sample_out, out_clipped
// cfg      input      cfg_we (no wait)    cfg_index, cfg_data
//
// A filter request occupies the block from the idle state in which it is
// accepted through six sequencer steps (B0, Y, A1, B2, A2, N2). Five steps each
// form one product on the single shared coef x sample multiplier (b0, b1, a1,
// b2, a2); each product is registered and accumulated in the step after it is
// formed. The result is registered as N2 finishes. A clear request passes
// through ST_CLR only, whose result is registered as it finishes. Only one
// request is in flight at a time.
// rst_n is synchronous, active low: coefficients return to pass-through,
// both delays to zero. A stalled result holds the last step until taken;
// a new request is accepted while a previous result still waits.
module biquad_iir_filter_df2t_top #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]   out_sample_out,
  output logic                             out_clipped,
  input  logic                             cfg_we,
  input  logic [bqd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [bqd_pkg::COEF_W-1:0]       cfg_data
);
  import bqd_pkg::*;

  // product width and accumulator width (two guard bits)
  localparam int PW = COEF_W + SAMPLE_WIDTH;
  localparam int AW = ((PW > DELAY_W) ? PW : DELAY_W) + 2;

  localparam logic signed [AW-1:0] Y_HI =
    {{(AW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] Y_LO = ~Y_HI;
  localparam logic signed [AW-1:0] D_HI =
    {{(AW-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
  localparam logic signed [AW-1:0] D_LO = ~D_HI;
  localparam logic signed [AW-1:0] RND  =
    {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS-1);

  state_t state_r, state_nxt;

  logic signed [COEF_W-1:0]       b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [DELAY_W-1:0]      z1_r, z1_nxt, z2_r, z2_nxt;
  logic signed [SAMPLE_WIDTH-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [PW-1:0]           prod_r, prod_nxt;
  logic signed [AW-1:0]           acc_r, acc_nxt;
  logic                           hit_r, hit_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_smp_r, out_smp_nxt;
  logic                           out_clip_r, out_clip_nxt;

  // shared multiplier operands
  logic signed [COEF_W-1:0]       mul_coef;
  logic signed [SAMPLE_WIDTH-1:0] mul_smp;
  logic signed [PW-1:0]           mul_res;

  logic signed [AW-1:0] prod_ext, sum_y, rnd_y, shf_y, diff;
  logic                 out_free, in_acc;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (state_r)
      ST_B0:   mul_coef = b0_r;
      ST_Y:    mul_coef = b1_r;
      ST_A1:   mul_coef = a1_r;
      ST_B2:   mul_coef = b2_r;
      ST_A2:   mul_coef = a2_r;
      default: mul_coef = b0_r;
    endcase
    mul_smp = (state_r == ST_A1 || state_r == ST_A2) ? y_r : x_r;
  end

  assign mul_res  = mul_coef * mul_smp;
  assign prod_ext = AW'(prod_r);
  assign sum_y    = prod_ext + AW'(z1_r);
  assign rnd_y    = sum_y + RND;
  assign shf_y    = rnd_y >>> COEF_FRAC_BITS;
  // feedback terms are subtracted from the running sum
  assign diff     = acc_r - prod_ext;

  always_comb begin
    state_nxt     = state_r;
    z1_nxt        = z1_r;
    z2_nxt        = z2_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_smp_nxt   = out_smp_r;
    out_clip_nxt  = out_clip_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          hit_nxt = 1'b0;
          x_nxt   = in_sample_in;
          if (in_kind == KIND_CLEAR) begin
            z1_nxt    = '0;
            z2_nxt    = '0;
            state_nxt = ST_CLR;
          end else begin
            state_nxt = ST_B0;
          end
        end
      end
      ST_B0: begin
        prod_nxt  = mul_res;
        state_nxt = ST_Y;
      end
      ST_Y: begin
        // round half up, then saturate to sample width
        if (shf_y > Y_HI) begin
          y_nxt   = Y_HI[SAMPLE_WIDTH-1:0];
          hit_nxt = 1'b1;
        end else if (shf_y < Y_LO) begin
          y_nxt   = Y_LO[SAMPLE_WIDTH-1:0];
          hit_nxt = 1'b1;
        end else begin
          y_nxt = shf_y[SAMPLE_WIDTH-1:0];
        end
        prod_nxt  = mul_res;
        state_nxt = ST_A1;
      end
      ST_A1: begin
        acc_nxt   = prod_ext + AW'(z2_r);
        prod_nxt  = mul_res;
        state_nxt = ST_B2;
      end
      ST_B2: begin
        if (diff > D_HI) begin
          z1_nxt  = D_HI[DELAY_W-1:0];
          hit_nxt = 1'b1;
        end else if (diff < D_LO) begin
          z1_nxt  = D_LO[DELAY_W-1:0];
          hit_nxt = 1'b1;
        end else begin
          z1_nxt = diff[DELAY_W-1:0];
        end
        prod_nxt  = mul_res;
        state_nxt = ST_A2;
      end
      ST_A2: begin
        acc_nxt   = prod_ext;
        prod_nxt  = mul_res;
        state_nxt = ST_N2;
      end
      ST_N2: begin
        if (out_free) begin
          if (diff > D_HI) begin
            z2_nxt       = D_HI[DELAY_W-1:0];
            out_clip_nxt = 1'b1;
          end else if (diff < D_LO) begin
            z2_nxt       = D_LO[DELAY_W-1:0];
            out_clip_nxt = 1'b1;
          end else begin
            z2_nxt       = diff[DELAY_W-1:0];
            out_clip_nxt = hit_r;
          end
          out_smp_nxt   = y_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CLR: begin
        if (out_free) begin
          out_smp_nxt   = '0;
          out_clip_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      z1_r        <= '0;
      z2_r        <= '0;
      b0_r        <= B0_RESET;
      b1_r        <= '0;
      b2_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      z1_r        <= z1_nxt;
      z2_r        <= z2_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_B0:  b0_r <= cfg_data;
          REG_B1:  b1_r <= cfg_data;
          REG_B2:  b2_r <= cfg_data;
          REG_A1:  a1_r <= cfg_data;
          REG_A2:  a2_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    hit_r      <= hit_nxt;
    out_smp_r  <= out_smp_nxt;
    out_clip_r <= out_clip_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_smp_r;
  assign out_clipped    = out_clip_r;

  // an accepted request always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted request did not start the sequencer");

  // last step retires straight into the result register
  a_n2_retire: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_N2 && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("final step did not deliver a result");

  // results only come from the two finishing states
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_N2 || $past(state_r) == ST_CLR))
    else $error("result raised outside a finishing state");

  // clear leaves both delays at zero
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> (z1_r == '0 && z2_r == '0))
    else $error("delays not cleared");

endmodule
